// ===== hdl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants, types and a helper function for the Sobel edge block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int RowW     = 12;
  localparam int WidthW   = 11;

  // APB register addresses
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd4;

  typedef logic [23:0] pix_t;

  // Per-channel squared gradient sum, max 2*1020^2
  typedef logic [20:0] sq_t;

  // Squared gradient magnitude of one channel over a 3x3 window
  // t*: top row, m*: middle row, b*: bottom row; l/c/r: columns
  function automatic sq_t grad_sq(
    input logic [7:0] tl, input logic [7:0] tc, input logic [7:0] tr,
    input logic [7:0] ml, input logic [7:0] mr,
    input logic [7:0] bl, input logic [7:0] bc, input logic [7:0] br
  );
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [21:0] s;
    gx = $signed({4'd0, tr}) + $signed({3'd0, mr, 1'b0}) + $signed({4'd0, br})
       - $signed({4'd0, tl}) - $signed({3'd0, ml, 1'b0}) - $signed({4'd0, bl});
    gy = $signed({4'd0, bl}) + $signed({3'd0, bc, 1'b0}) + $signed({4'd0, br})
       - $signed({4'd0, tl}) - $signed({3'd0, tc, 1'b0}) - $signed({4'd0, tr});
    s = 22'(gx * gx) + 22'(gy * gy);
    return s[20:0];
  endfunction

endpackage

// ===== hdl/sobel_line_store.sv =====
// ----------------------------------------------------------------------------
// sobel_line_store
// Two row memories with registered read; each column read is written back
// shifted down one row in the following cycle.
// ----------------------------------------------------------------------------
module sobel_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [sobel_pkg::AddrW-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [sobel_pkg::AddrW-1:0] wr_addr,
  input  sobel_pkg::pix_t           wr_above,
  input  sobel_pkg::pix_t           wr_two,
  output sobel_pkg::pix_t           rd_above,
  output sobel_pkg::pix_t           rd_two
);

  sobel_pkg::pix_t mem_above [sobel_pkg::MaxWidth];
  sobel_pkg::pix_t mem_two   [sobel_pkg::MaxWidth];

  // Write back and read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_above[wr_addr] <= wr_above;
      mem_two[wr_addr]   <= wr_two;
    end
    if (rd_en) begin
      rd_above <= mem_above[rd_addr];
      rd_two   <= mem_two[rd_addr];
    end
  end

endmodule

// ===== hdl/sobel_root.sv =====
// ----------------------------------------------------------------------------
// sobel_root
// Rounded integer square root of a 21-bit value, saturated at 255,
// computed one result bit per cycle.
// ----------------------------------------------------------------------------
module sobel_root (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sobel_pkg::sq_t value,
  output logic          done,
  output logic [7:0]    root
);

  sobel_pkg::sq_t s;
  logic [10:0] r;
  logic [10:0] bitm;
  logic        busy;
  logic [10:0] t;
  logic [21:0] tsq;
  logic [21:0] rem;
  logic [11:0] rr;

  assign t   = r | bitm;
  assign tsq = 22'(t) * 22'(t);
  assign rem = 22'(s) - 22'(r) * 22'(r);
  assign rr  = (rem > 22'(r)) ? 12'(r) + 12'd1 : 12'(r);
  assign root = (rr > 12'd255) ? 8'd255 : rr[7:0];

  // Advance one bit per cycle from the top
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        s    <= value;
        r    <= '0;
        bitm <= 11'h400;
        busy <= 1'b1;
      end else if (busy) begin
        if (tsq <= 22'(s)) r <= t;
        bitm <= bitm >> 1;
        if (bitm == 11'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude per RGB channel.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the s_axis channel in raster order, one word each;
// tdata = {blue, green, red} (red lowest), tuser = flush. After the last
// pixel of a frame send image_width+1 flush words. Results leave on m_axis,
// tdata = {blue, green, red} edge magnitudes, tlast = frame end. Each
// result belongs to the pixel one row up and one column left of the word
// that caused it.
// Sequence: one word is handled at a time, in order: accept it, read the
// line stores, form the gradient sums, load the root units, run the
// bit-serial square roots, see them done and load the result register
// once it is free. A word that gives no result returns to idle after the
// gradient sums. Width and height are written over APB at 0x0 and 0x4;
// the user must write them only while idle, which the block does not
// enforce. Reset clears the position and window; the line stores are not
// cleared. A stalled receiver holds the result register and blocks further
// input once the next result is ready.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  input  logic        s_axis_tuser,  // flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red_edge, green_edge, blue_edge
  output logic        m_axis_tlast,  // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_ROOT, S_OUT} state_t;

  state_t state;
  logic [sobel_pkg::WidthW-1:0] image_width;
  logic [sobel_pkg::RowW-1:0]   image_height;
  logic [sobel_pkg::WidthW-1:0] in_column;
  // One spare bit: the position reaches the row after the flush row
  logic [sobel_pkg::RowW:0]     in_row;
  sobel_pkg::pix_t win [3][3];
  sobel_pkg::pix_t pix;
  logic            pix_flush;
  logic [sobel_pkg::AddrW-1:0] addr;
  sobel_pkg::pix_t rd_above;
  sobel_pkg::pix_t rd_two;
  sobel_pkg::pix_t col [3];
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic        valid_res;
  logic        fe;
  logic        wrap;
  logic        wr_en;
  sobel_pkg::sq_t sq [3];
  logic        root_start;
  logic [2:0]  root_done;
  logic [7:0]  root [3];
  logic        pend_fe;

  assign pready = 1'b1;
  assign prdata = (paddr == sobel_pkg::RegHeight) ? 32'(image_height) : 32'(image_width);

  // Effective geometry
  assign w_eff = (image_width == '0) ? 12'd1 :
                 (image_width > 11'(sobel_pkg::MaxWidth)) ? 12'(sobel_pkg::MaxWidth) :
                 12'(image_width);
  assign h_eff = (image_height == '0) ? 13'd1 : 13'(image_height);
  assign addr  = (12'(in_column) < 12'(sobel_pkg::MaxWidth)) ?
                 in_column[sobel_pkg::AddrW-1:0] : sobel_pkg::AddrW'(sobel_pkg::MaxWidth - 1);

  // Column assembled from the line stores and the incoming pixel
  assign col[0] = (in_row >= 13'd2) ? rd_two : '0;
  assign col[1] = (in_row >= 13'd1) ? rd_above : '0;
  assign col[2] = (pix_flush || in_row >= h_eff) ? '0 : pix;

  assign wr_en = (state == S_CALC);
  assign valid_res = (in_column == '0) ?
                     (in_row >= 13'd2 && in_row - 13'd2 < h_eff) :
                     (in_row >= 13'd1 && in_row - 13'd1 < h_eff);
  assign fe   = (in_column == '0) && valid_res && (in_row - 13'd2 == h_eff - 13'd1);
  assign wrap = (in_column == '0) && (in_row >= h_eff + 13'd1);

  sobel_line_store u_lines (
    .clk      (clk),
    .rd_en    (state == S_READ),
    .rd_addr  (addr),
    .wr_en    (wr_en),
    .wr_addr  (addr),
    .wr_above (col[2]),
    .wr_two   (rd_above),
    .rd_above (rd_above),
    .rd_two   (rd_two)
  );

  // One square root unit per channel on the squared gradient sums
  for (genvar c = 0; c < 3; c++) begin : g_ch
    sobel_root u_root (
      .clk   (clk),
      .rst   (rst),
      .start (root_start),
      .value (sq[c]),
      .done  (root_done[c]),
      .root  (root[c])
    );
  end

  // Squared magnitudes are computed on the window after the shift
  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      for (int c = 0; c < 3; c++) begin
        sq[c] <= sobel_pkg::grad_sq(
          win[0][1][8*c +: 8], win[0][2][8*c +: 8],
          (in_column == '0) ? 8'd0 : col[0][8*c +: 8],
          win[1][1][8*c +: 8],
          (in_column == '0) ? 8'd0 : col[1][8*c +: 8],
          win[2][1][8*c +: 8], win[2][2][8*c +: 8],
          (in_column == '0) ? 8'd0 : col[2][8*c +: 8]);
      end
    end
  end

  // Sequencer, window, position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= 11'd640;
      image_height  <= 12'd480;
      in_column     <= '0;
      in_row        <= '0;
      m_axis_tvalid <= 1'b0;
      root_start    <= 1'b0;
      pend_fe       <= 1'b0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) win[a][b] <= '0;
    end else begin
      root_start <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr == sobel_pkg::RegWidth)  image_width  <= pwdata[10:0];
        if (paddr == sobel_pkg::RegHeight) image_height <= pwdata[11:0];
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            pix       <= s_axis_tdata;
            pix_flush <= s_axis_tuser;
            state     <= S_READ;
          end
        end
        S_READ: state <= S_CALC;
        S_CALC: begin
          pend_fe <= fe;
          if (valid_res) begin
            root_start <= 1'b1;
            state      <= S_ROOT;
          end else begin
            state <= S_IDLE;
          end
          // Update window and position
          for (int a = 0; a < 3; a++) begin
            if (in_column == '0 || wrap) begin
              win[a][0] <= '0;
              win[a][1] <= '0;
              win[a][2] <= wrap ? '0 : col[a];
            end else begin
              win[a][0] <= win[a][1];
              win[a][1] <= win[a][2];
              win[a][2] <= col[a];
            end
          end
          if (wrap) begin
            in_column <= '0;
            in_row    <= '0;
          end else if (12'(in_column) + 12'd1 >= w_eff) begin
            in_column <= '0;
            in_row    <= in_row + 13'd1;
          end else begin
            in_column <= in_column + 11'd1;
          end
        end
        S_ROOT: begin
          if (root_done[0]) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {root[2], root[1], root[0]};
            m_axis_tlast  <= pend_fe;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_roots_together: assert property (@(posedge clk) disable iff (rst)
    root_done[0] |-> root_done[1] && root_done[2])
    else $error("root units out of step");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    12'(in_column) < w_eff || state != S_IDLE || $past(psel))
    else $error("column past row end");

endmodule

// ===== test/tb_sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams RGB frames of many sizes through the block and checks every
// edge word against an in-bench prediction of the 3x3 Sobel magnitude.
// Covers zero geometry, saturation, flush and zero-padded regions,
// random bursts, a stalled receiver and a fully drained sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_rgb;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } edge_word_t;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 40;
  localparam int WordTarget = 1850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sobel_edge_magnitude_rgb i_dut (.*);

  always #5 clk = ~clk;

  // Predicted geometry and pixel pipeline state
  logic [10:0] geom_width = 11'd640;
  logic [11:0] geom_height = 12'd480;
  logic [23:0] line_above [sobel_pkg::MaxWidth];
  logic [23:0] line_two_above [sobel_pkg::MaxWidth];
  logic [23:0] win [3][3];
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  edge_word_t edge_q[$];
  int errors = 0;
  int n_words = 0;
  int n_edges = 0;
  int n_frames = 0;
  int burst_left = 0;
  int cycles = 0;
  bit rx_stalls = 1'b0;
  bit hold_go = 1'b0;
  int hold_left = 0;

  // Exact integer square root, rounded to nearest, saturated at 255
  function automatic logic [7:0] round_sqrt(input int unsigned s);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [7:0] chan_magnitude(input int ch);
    int gx;
    int gy;
    int v [3][3];
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) v[a][b] = win[a][b][8*ch +: 8];
    gx = v[0][2] + 2 * v[1][2] + v[2][2] - v[0][0] - 2 * v[1][0] - v[2][0];
    gy = v[2][0] + 2 * v[2][1] + v[2][2] - v[0][0] - 2 * v[0][1] - v[0][2];
    return round_sqrt(gx * gx + gy * gy);
  endfunction

  // Advance the predicted pipeline by one word; return 1 when it yields an edge
  function automatic bit predict_edge(input logic [23:0] pix, input logic flush,
                                      output edge_word_t ew);
    int unsigned w;
    int unsigned h;
    logic [23:0] fresh [3];
    bit hit;
    bit fe;
    w = (geom_width == 0) ? 1 :
        ((geom_width > sobel_pkg::MaxWidth) ? sobel_pkg::MaxWidth : geom_width);
    h = (geom_height == 0) ? 1 : geom_height;
    fresh[0] = (pos_row >= 2) ? line_two_above[pos_col] : '0;
    fresh[1] = (pos_row >= 1) ? line_above[pos_col] : '0;
    fresh[2] = (flush || pos_row >= h) ? '0 : pix;
    line_two_above[pos_col] = line_above[pos_col];
    line_above[pos_col] = fresh[2];
    fe = 1'b0;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
      win[a][2] = (pos_col == 0) ? '0 : fresh[a];
    end
    if (pos_col == 0) begin
      hit = pos_row >= 2 && pos_row - 2 < h;
      fe = hit && pos_row - 2 == h - 1;
    end else begin
      hit = pos_row >= 1 && pos_row - 1 < h;
    end
    ew.red = chan_magnitude(0);
    ew.green = chan_magnitude(1);
    ew.blue = chan_magnitude(2);
    ew.fend = fe;
    if (pos_col == 0) begin
      for (int a = 0; a < 3; a++) begin
        win[a][0] = '0;
        win[a][1] = '0;
        win[a][2] = fresh[a];
      end
    end
    // Wrap the frame after its last result, else step through the raster
    if (pos_col == 0 && pos_row >= h + 1) begin
      pos_col = 0;
      pos_row = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) win[a][b] = '0;
    end else begin
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
      end
    end
    return hit;
  endfunction

  // Predict on each accepted pixel word, check each accepted edge word
  always @(posedge clk) begin
    edge_word_t ew;
    edge_word_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_words++;
        if (predict_edge(s_axis_tdata, s_axis_tuser, ew)) edge_q.push_back(ew);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_edges++;
        if (edge_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected edge word tdata=%h tlast=%b", $time,
                   m_axis_tdata, m_axis_tlast);
        end else begin
          want = edge_q.pop_front();
          if (m_axis_tdata !== {want.blue, want.green, want.red} ||
              m_axis_tlast !== want.fend) begin
            errors++;
            $display("%0t: edge mismatch expected tdata=%h tlast=%b actual tdata=%h tlast=%b",
                     $time, {want.blue, want.green, want.red}, want.fend,
                     m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // Receiver: random stall pattern when enabled, else always ready, plus a long hold on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go <= 1'b0;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls) begin
      m_axis_tready <= ($urandom_range(0, 9) > 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one pixel word, in bursts with random gaps
  task automatic send_word(input logic [23:0] pix, input logic flush);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= flush;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Pause the sender until every expected edge has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == sobel_pkg::RegWidth) geom_width = data[10:0];
    else geom_height = data[11:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h);
    drain();
    apb_write(sobel_pkg::RegWidth, w);
    apb_write(sobel_pkg::RegHeight, h);
  endtask

  // One frame plus its flush tail; style picks the pixel content
  // 0 random, 1 all full, 2 checkerboard, 3 random with holes and junk tail
  task automatic send_frame(input int style);
    int w;
    int h;
    logic [23:0] pix;
    w = (geom_width == 0) ? 1 :
        ((geom_width > sobel_pkg::MaxWidth) ? sobel_pkg::MaxWidth : geom_width);
    h = (geom_height == 0) ? 1 : geom_height;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (style)
          1: pix = 24'hFFFFFF;
          2: pix = ((r + c) % 2) ? 24'hFFFFFF : 24'h000000;
          default: pix = 24'($urandom());
        endcase
        send_word(pix, style == 3 && $urandom_range(0, 9) == 0);
      end
    // The tail may carry junk pixels with flush low; they read as zero
    for (int i = 0; i <= w; i++)
      send_word(24'($urandom()), !(style == 3 && $urandom_range(0, 1) == 0));
    n_frames++;
  endtask

  task automatic test_saturation();
    set_geometry(3, 3);
    send_frame(1);
    send_frame(2);
    set_geometry(4, 2);
    send_frame(2);
  endtask

  task automatic test_flush_regions();
    set_geometry(5, 3);
    send_frame(3);
    set_geometry(1, 1);
    send_frame(3);
  endtask

  task automatic test_geometry_limits();
    set_geometry(0, 0);
    send_frame(0);
    set_geometry(2, 1);
    send_frame(3);
  endtask

  task automatic test_backpressure();
    set_geometry(6, 4);
    hold_go <= 1'b1;
    send_frame(0);
    send_frame(3);
  endtask

  task automatic test_random_frames();
    rx_stalls = 1'b1;
    while (n_words < WordTarget) begin
      set_geometry($urandom_range(1, 9), $urandom_range(1, 7));
      send_frame($urandom_range(0, 3) == 0 ? 3 : 0);
      if ($urandom_range(0, 7) == 0) rx_stalls = ~rx_stalls;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_saturation();
    test_flush_regions();
    test_geometry_limits();
    rx_stalls = 1'b1;
    test_backpressure();
    test_random_frames();
    drain();
    $display("covered %0d frames, %0d pixel words in, %0d edge words checked",
             n_frames, n_words, n_edges);
    $display("sizes from 1x1 to 9x7 plus zero geometry, with stalls and flush tails");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
